FILE: hdl/mm_pkg.sv
// shared types, constants and helpers for the matrix multiply block
package mm_pkg;

    // size limits and field widths
    localparam int MAX_DIM = 8;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CFG_W   = 4;
    localparam int IDX_W   = 2;
    localparam int ELEM_W  = 16;
    localparam int MUL_W   = 2 * ELEM_W;
    localparam int PROD_W  = 40;
    localparam int CNT_W   = $clog2(2 * DEPTH + 1);

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } reg_idx_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_WAIT,
        ST_DRAIN
    } state_t;

    // one element of A travelling down the chain of cells
    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic [DIM_W-1:0]         t;
        logic signed [ELEM_W-1:0] a;
    } lane_t;

    // broadcast write of one element of B into its column cell
    typedef struct packed {
        logic                     we;
        logic [DIM_W-1:0]         t;
        logic [DIM_W-1:0]         col;
        logic signed [ELEM_W-1:0] data;
    } bwr_t;

    // size register to size in use: zero counts as one, large values saturate
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CFG_W'(1);
        end
        else if (v > CFG_W'(MAX_DIM))
        begin
            r = CFG_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

FILE: hdl/mm_ram.sv
// generic simple dual-port ram with registered read
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/mm_cell.sv
// one column cell: holds a column of B, multiplies passing A elements, accumulates
module mm_cell (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [mm_pkg::DIM_W-1:0]                 index,
    input  mm_pkg::bwr_t                             bwr,
    input  mm_pkg::lane_t                            lane_in,
    output mm_pkg::lane_t                            lane_out,
    output logic signed [mm_pkg::PROD_W-1:0]         sum,
    output logic                                     done
);
    import mm_pkg::*;

    logic signed [ELEM_W-1:0] bcol_reg [MAX_DIM];
    lane_t                    lane_reg;
    logic signed [MUL_W-1:0]  mul_reg;
    logic                     mul_valid_reg;
    logic                     mul_first_reg;
    logic                     mul_last_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;
    logic                     done_reg;

    // column store of B, written when the element belongs to this column
    always_ff @(posedge clk)
    begin
        if (bwr.we && (bwr.col == index))
        begin
            bcol_reg[bwr.t] <= bwr.data;
        end
    end

    // hop register towards the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else
        begin
            lane_reg <= lane_in;
        end
    end

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= lane_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg       <= lane_reg.a * bcol_reg[lane_reg.t];
        mul_first_reg <= lane_reg.first;
        mul_last_reg  <= lane_reg.last;
    end

    // accumulate, restarting on the first term of a row
    always_comb
    begin
        acc_next = (mul_first_reg ? PROD_W'(0) : acc_reg) + PROD_W'(mul_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mul_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // pulse once the dot product of a row is complete
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mul_valid_reg && mul_last_reg;
        end
    end

    assign lane_out = lane_reg;
    assign sum      = acc_reg;
    assign done     = done_reg;

endmodule

FILE: hdl/matrix_multiply_top.sv
// top level of the matrix multiply block: load, sequencer, cell chain and output register
//
// Elements of A (row-major) and then B (row-major) are taken one per cycle; A goes into a
// 64-entry ram, each element of B into the cell of its column. Once the last element of B
// is in, the block stalls its input and works row by row: the row of A is read from the
// ram one element a cycle and passes along a chain of eight column cells, one hop a cycle,
// each cell multiplying and accumulating against its column of B. A row takes inner_dim
// reads of the ram; once the sum of the final column is ready, cols_b output transfers
// follow. The next load starts once the final result sits in the output register. A
// write to a size register while loading restarts the load.
module matrix_multiply_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [mm_pkg::IDX_W-1:0]              cfg_index,
    input  logic [mm_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [mm_pkg::ELEM_W-1:0]      element,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mm_pkg::PROD_W-1:0]      product,
    output logic [mm_pkg::DIM_W-1:0]              row,
    output logic [mm_pkg::DIM_W-1:0]              col,
    output logic                                  last
);
    import mm_pkg::*;

    // configuration
    logic [CFG_W-1:0]   rows_a_reg;
    logic [CFG_W-1:0]   inner_dim_reg;
    logic [CFG_W-1:0]   cols_b_reg;
    logic [CFG_W-1:0]   m_eff;
    logic [CFG_W-1:0]   k_eff;
    logic [CFG_W-1:0]   n_eff;
    logic [DIM_W-1:0]   m_last;
    logic [DIM_W-1:0]   k_last;
    logic [DIM_W-1:0]   n_last;
    logic [CNT_W-1:0]   size_a;
    logic [CNT_W-1:0]   total;
    logic               cfg_hit;

    // sequencer
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   load_cnt_reg;
    logic [CNT_W-1:0]   load_cnt_next;
    logic [DIM_W-1:0]   bt_reg;
    logic [DIM_W-1:0]   bt_next;
    logic [DIM_W-1:0]   bc_reg;
    logic [DIM_W-1:0]   bc_next;
    logic [ADDR_W-1:0]  a_addr_reg;
    logic [ADDR_W-1:0]  a_addr_next;
    logic [DIM_W-1:0]   t_reg;
    logic [DIM_W-1:0]   t_next;
    logic [DIM_W-1:0]   row_cnt_reg;
    logic [DIM_W-1:0]   row_cnt_next;
    logic [DIM_W-1:0]   col_cnt_reg;
    logic [DIM_W-1:0]   col_cnt_next;
    logic               in_accept;
    logic               ram_we;
    logic               issue;
    logic               load_out;
    bwr_t               bwr;

    // feed into the first cell
    logic               feed_valid_reg;
    logic               feed_first_reg;
    logic               feed_last_reg;
    logic [DIM_W-1:0]   feed_t_reg;
    logic [ELEM_W-1:0]  ram_rdata;

    // cell chain
    lane_t                    lanes [MAX_DIM+1];
    logic signed [PROD_W-1:0] sums  [MAX_DIM];
    logic [MAX_DIM-1:0]       done_vec;

    // output register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [PROD_W-1:0] product_reg;
    logic [DIM_W-1:0]         row_reg;
    logic [DIM_W-1:0]         col_reg;
    logic                     last_reg;

    // sizes in use
    assign m_eff   = clamp_dim(rows_a_reg);
    assign k_eff   = clamp_dim(inner_dim_reg);
    assign n_eff   = clamp_dim(cols_b_reg);
    assign m_last  = DIM_W'(m_eff - CFG_W'(1));
    assign k_last  = DIM_W'(k_eff - CFG_W'(1));
    assign n_last  = DIM_W'(n_eff - CFG_W'(1));
    assign size_a  = CNT_W'({4'd0, m_eff} * {4'd0, k_eff});
    assign total   = size_a + CNT_W'({4'd0, k_eff} * {4'd0, n_eff});
    assign cfg_hit = cfg_write && ((cfg_index == REG_ROWS_A) ||
                                   (cfg_index == REG_INNER_DIM) ||
                                   (cfg_index == REG_COLS_B));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_W'(MAX_DIM);
            inner_dim_reg <= CFG_W'(MAX_DIM);
            cols_b_reg    <= CFG_W'(MAX_DIM);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_accept = in_valid && !in_stall;

    // next state and control
    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        bt_next       = bt_reg;
        bc_next       = bc_reg;
        a_addr_next   = a_addr_reg;
        t_next        = t_reg;
        row_cnt_next  = row_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        ram_we        = 1'b0;
        issue         = 1'b0;
        load_out      = 1'b0;
        bwr.we        = 1'b0;
        bwr.t         = bt_reg;
        bwr.col       = bc_reg;
        bwr.data      = element;
        case (state_reg)
            ST_LOAD:
            begin
                if (cfg_hit)
                begin
                    load_cnt_next = '0;
                    bt_next       = '0;
                    bc_next       = '0;
                end
                else if (in_accept)
                begin
                    if (load_cnt_reg < size_a)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        bwr.we = 1'b1;
                        if (bc_reg == n_last)
                        begin
                            bc_next = '0;
                            bt_next = bt_reg + DIM_W'(1);
                        end
                        else
                        begin
                            bc_next = bc_reg + DIM_W'(1);
                        end
                    end
                    if (load_cnt_reg == total - CNT_W'(1))
                    begin
                        load_cnt_next = '0;
                        bt_next       = '0;
                        bc_next       = '0;
                        a_addr_next   = '0;
                        t_next        = '0;
                        row_cnt_next  = '0;
                        state_next    = ST_CALC;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_CALC:
            begin
                issue       = 1'b1;
                a_addr_next = a_addr_reg + ADDR_W'(1);
                if (t_reg == k_last)
                begin
                    t_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    t_next = t_reg + DIM_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (done_vec[n_last])
                begin
                    col_cnt_next = '0;
                    state_next   = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out = 1'b1;
                    if (col_cnt_reg == n_last)
                    begin
                        col_cnt_next = '0;
                        if (row_cnt_reg == m_last)
                        begin
                            row_cnt_next = '0;
                            state_next   = ST_LOAD;
                        end
                        else
                        begin
                            row_cnt_next = row_cnt_reg + DIM_W'(1);
                            state_next   = ST_CALC;
                        end
                    end
                    else
                    begin
                        col_cnt_next = col_cnt_reg + DIM_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            bt_reg       <= '0;
            bc_reg       <= '0;
            a_addr_reg   <= '0;
            t_reg        <= '0;
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            bt_reg       <= bt_next;
            bc_reg       <= bc_next;
            a_addr_reg   <= a_addr_next;
            t_reg        <= t_next;
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
        end
    end

    // store of A
    mm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_cnt_reg[ADDR_W-1:0]),
        .wdata (element),
        .raddr (a_addr_reg),
        .rdata (ram_rdata)
    );

    // tags that line up with the ram read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_valid_reg <= 1'b0;
        end
        else
        begin
            feed_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        feed_t_reg     <= t_reg;
        feed_first_reg <= (t_reg == '0);
        feed_last_reg  <= (t_reg == k_last);
    end

    assign lanes[0] = '{valid: feed_valid_reg, first: feed_first_reg, last: feed_last_reg,
                        t: feed_t_reg, a: ram_rdata};

    // chain of column cells
    for (genvar j = 0; j < MAX_DIM; j++)
    begin : g_cell
        mm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .index    (DIM_W'(j)),
            .bwr      (bwr),
            .lane_in  (lanes[j]),
            .lane_out (lanes[j+1]),
            .sum      (sums[j]),
            .done     (done_vec[j])
        );
    end

    // output register, refilled while its content is being taken
    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            product_reg <= sums[col_cnt_reg];
            row_reg     <= row_cnt_reg;
            col_reg     <= col_cnt_reg;
            last_reg    <= (row_cnt_reg == m_last) && (col_cnt_reg == n_last);
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;
    assign row       = row_reg;
    assign col       = col_reg;
    assign last      = last_reg;

endmodule

FILE: dv/tb_matrix_multiply_top.sv
// self-checking testbench for the matrix multiply block with its own product predictor
`timescale 1ns / 100ps

module tb_matrix_multiply_top;

    import mm_pkg::*;

    // timing and limits
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASE_ITEMS   = 50;

    // register index that decodes to nothing
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    // element extremes
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;

    // one element of the result matrix
    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic [DIM_W-1:0]         row;
        logic [DIM_W-1:0]         col;
        logic                     last;
    } c_elem_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    // block ports
    logic                     cfg_write = 1'b0;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [ELEM_W-1:0] element   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [PROD_W-1:0] product;
    logic [DIM_W-1:0]         row;
    logic [DIM_W-1:0]         col;
    logic                     last;

    matrix_multiply_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .element   (element),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .product   (product),
        .row       (row),
        .col       (col),
        .last      (last)
    );

    // stimulus and expectation stores
    logic signed [ELEM_W-1:0] pending_elements [$];
    c_elem_t                  expected_c [$];
    c_elem_t                  c_head;

    // predictor state
    logic [CFG_W-1:0]         size_rows  = CFG_W'(8);
    logic [CFG_W-1:0]         size_inner = CFG_W'(8);
    logic [CFG_W-1:0]         size_cols  = CFG_W'(8);
    int                       fill_count = 0;
    logic signed [ELEM_W-1:0] mat_a [DEPTH];
    logic signed [ELEM_W-1:0] mat_b [DEPTH];

    // run statistics and idling control
    int mismatches      = 0;
    int elements_queued = 0;
    int elements_taken  = 0;
    int results_checked = 0;
    int settings_run    = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int quiet_cycles    = 0;

    // register value to dimension in use
    function automatic int dim_in_use(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > CFG_W'(MAX_DIM))
        begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // store one element and emit the whole product once b is complete
    task automatic load_and_multiply(input logic signed [ELEM_W-1:0] e);
        int m;
        int k;
        int n;
        int size_a;
        int total;
        int i;
        int j;
        int t;
        logic signed [63:0] acc;
        c_elem_t r;
        m = dim_in_use(size_rows);
        k = dim_in_use(size_inner);
        n = dim_in_use(size_cols);
        size_a = m * k;
        total  = size_a + k * n;
        if (fill_count >= total)
        begin
            fill_count = 0;
        end
        if (fill_count < size_a)
        begin
            mat_a[fill_count] = e;
        end
        else
        begin
            mat_b[fill_count - size_a] = e;
        end
        fill_count++;
        if (fill_count == total)
        begin
            fill_count = 0;
            for (i = 0; i < m; i++)
            begin
                for (j = 0; j < n; j++)
                begin
                    acc = '0;
                    for (t = 0; t < k; t++)
                    begin
                        acc += mat_a[i * k + t] * mat_b[t * n + j];
                    end
                    r.product = acc[PROD_W-1:0];
                    r.row     = i[DIM_W-1:0];
                    r.col     = j[DIM_W-1:0];
                    r.last    = (i == m - 1) && (j == n - 1);
                    expected_c.push_back(r);
                end
            end
        end
    endtask

    // mirror a register write; any known index restarts the load
    task automatic note_reg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_ROWS_A:    size_rows  = data;
            REG_INNER_DIM: size_inner = data;
            REG_COLS_B:    size_cols  = data;
            default:       return;
        endcase
        fill_count = 0;
    endtask

    // input driver: keeps a stalled transfer steady, idles at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                load_and_multiply(element);
                elements_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_elements.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    element  <= pending_elements.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: checks each transfer against the oldest expected element
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_c.size() == 0)
                begin
                    $error("unexpected result: product %0d row %0d col %0d last %0d",
                           product, row, col, last);
                    mismatches++;
                end
                else
                begin
                    c_head = expected_c.pop_front();
                    if (product !== c_head.product)
                    begin
                        $error("product mismatch: expected %0d, actual %0d",
                               $signed(c_head.product), product);
                        mismatches++;
                    end
                    if (row !== c_head.row)
                    begin
                        $error("row mismatch: expected %0d, actual %0d", c_head.row, row);
                        mismatches++;
                    end
                    if (col !== c_head.col)
                    begin
                        $error("col mismatch: expected %0d, actual %0d", c_head.col, col);
                        mismatches++;
                    end
                    if (last !== c_head.last)
                    begin
                        $error("last mismatch: expected %0d, actual %0d", c_head.last, last);
                        mismatches++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // watchdog on cycles without any transfer or register write
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("no transfer for %0d cycles, %0d results still expected",
                 QUIET_LIMIT, expected_c.size());
        $display("matrix_multiply_top test failed");
        $finish;
    end

    // one register write, mirrored at the edge that takes it
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        note_reg_write(idx, data);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_element(input logic signed [ELEM_W-1:0] e);
        pending_elements.push_back(e);
        elements_queued++;
    endtask

    // random element with the extremes weighted up
    function automatic logic signed [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 7))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // mostly small sizes, now and then any register value
    function automatic logic [CFG_W-1:0] random_size();
        if ($urandom_range(0, 99) < 15)
        begin
            return CFG_W'($urandom_range(0, 15));
        end
        return CFG_W'($urandom_range(1, 4));
    endfunction

    // wait until every queued element is taken, all results are out and the block has settled
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (pending_elements.size() != 0 || elements_taken != elements_queued ||
               expected_c.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one size setting: whole loads, then now and then a broken load
    task automatic run_setting(input logic [CFG_W-1:0] r_rows, input logic [CFG_W-1:0] r_inner,
                               input logic [CFG_W-1:0] r_cols);
        int total;
        int loads;
        int part;
        write_reg(REG_ROWS_A, r_rows);
        write_reg(REG_INNER_DIM, r_inner);
        write_reg(REG_COLS_B, r_cols);
        total = dim_in_use(r_rows) * dim_in_use(r_inner)
              + dim_in_use(r_inner) * dim_in_use(r_cols);
        loads = $urandom_range(1, 3);
        repeat (loads)
        begin
            repeat (total) queue_element(random_element());
        end
        wait_idle();
        if (total > 1 && $urandom_range(0, 3) == 0)
        begin
            part = $urandom_range(1, total - 1);
            repeat (part) queue_element(random_element());
            wait_idle();
            // either finish across a write to the unused index or leave it for a restart
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 15)));
                repeat (total - part) queue_element(random_element());
                wait_idle();
            end
        end
        settings_run++;
    endtask

    // stimulus sequence
    initial
    begin
        int phase;
        int phase_start;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scalar products at the element extremes
        write_reg(REG_ROWS_A, CFG_W'(1));
        write_reg(REG_INNER_DIM, CFG_W'(1));
        write_reg(REG_COLS_B, CFG_W'(1));
        queue_element(ELEM_MAX);
        queue_element(ELEM_MAX);
        queue_element(ELEM_MIN);
        queue_element(ELEM_MIN);
        queue_element(ELEM_MAX);
        queue_element(ELEM_MIN);
        wait_idle();

        // write to the unused index leaves a load in progress alone
        queue_element(16'sh1234);
        wait_idle();
        write_reg(REG_UNUSED, CFG_W'(15));
        queue_element(-16'sd5);
        wait_idle();

        // a size write restarts a load in progress
        queue_element(16'sh4000);
        wait_idle();
        write_reg(REG_COLS_B, CFG_W'(1));
        queue_element(16'sh0100);
        queue_element(16'shFF00);
        wait_idle();

        // zero sizes read as one, oversize inner reads as eight: largest positive sum
        write_reg(REG_ROWS_A, CFG_W'(0));
        write_reg(REG_INNER_DIM, CFG_W'(15));
        write_reg(REG_COLS_B, CFG_W'(0));
        repeat (16) queue_element(ELEM_MIN);
        wait_idle();

        // random settings under each idling pattern
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            if (phase == 3)
            begin
                // one whole load at the largest sizes, oversize column count
                write_reg(REG_ROWS_A, CFG_W'(8));
                write_reg(REG_INNER_DIM, CFG_W'(8));
                write_reg(REG_COLS_B, CFG_W'(15));
                repeat (2 * DEPTH) queue_element(random_element());
                wait_idle();
                settings_run++;
            end
            phase_start = elements_queued;
            while (elements_queued - phase_start < PHASE_ITEMS)
            begin
                run_setting(random_size(), random_size(), random_size());
            end
        end

        wait_idle();
        $display("covered %0d size settings: %0d elements in, %0d result elements checked",
                 settings_run, elements_taken, results_checked);
        $display("idling phases: none, sender 75%%, receiver 75%%, both 37%%; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_c.size() == 0)
        begin
            $display("matrix_multiply_top test passed");
        end
        else
        begin
            $display("matrix_multiply_top test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/mm_pkg.sv
hdl/mm_ram.sv
hdl/mm_cell.sv
hdl/matrix_multiply_top.sv
dv/tb_matrix_multiply_top.sv
